[design/tks_pkg.sv]
// tks_pkg: shared constants and types for the top-k score selection block
// used by tks_cell, top_k_score_select and tks_checker; depends on nothing
package tks_pkg;

  localparam int MAX_KEEP = 16;
  localparam int SCORE_W  = 15;
  localparam int GROUP_W  = 16;
  localparam int KEEP_W   = 5;
  localparam int CNT_W    = $clog2(MAX_KEEP + 1);

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(8);

  // one kept entry as it sits in a cell
  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] score;
    logic [GROUP_W-1:0] group;
  } entry_t;

  // per-cell control from the top level
  typedef struct packed {
    logic active;  // cell index below the effective keep count
    logic insert;  // input transfer this cycle
    logic shift;   // output transfer, move entries one cell toward the head
    logic flush;   // final output transfer, empty every cell
  } cell_ctl_t;

endpackage

[design/tks_cell.sv]
// tks_cell: one slot of the sorted keep chain, compares against the new score
// and takes the new item, its upper neighbor or its lower neighbor; uses tks_pkg
module tks_cell (
  input  logic               clk,
  input  logic               rst,
  input  tks_pkg::cell_ctl_t ctl,
  input  tks_pkg::entry_t    new_entry,
  input  tks_pkg::entry_t    prev_entry,
  input  logic               prev_gt,
  input  tks_pkg::entry_t    next_entry,
  output tks_pkg::entry_t    entry,
  output logic               gt
);
  import tks_pkg::*;

  entry_t               slot;
  entry_t               slot_next;
  logic [SCORE_W-1:0]   cur_score;

  // an empty slot counts as score zero
  assign cur_score = slot.valid ? slot.score : '0;
  assign gt        = ctl.active && (new_entry.score > cur_score);
  assign entry     = slot;

  always_comb begin
    slot_next = slot;
    if (ctl.flush) begin
      slot_next.valid = 1'b0;
    end else if (ctl.insert) begin
      if (!ctl.active) begin
        slot_next.valid = 1'b0;
      end else if (gt) begin
        slot_next = prev_gt ? prev_entry : new_entry;
      end
    end else if (ctl.shift) begin
      slot_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.score <= slot_next.score;
    slot.group <= slot_next.group;
  end

endmodule

[design/top_k_score_select.sv]
// top_k_score_select: streaming top-k selection built as a chain of tks_cell
// slots with a drain phase on the last item; uses tks_pkg and tks_cell
//
// Keeps the best keep_count entries (1..16, reset 8) of a batch of score items,
// sorted from highest to lowest score; a score enters only when strictly above
// the lowest kept score (an empty slot counts as zero), and on a tie the earlier
// entry stays ahead. Every cell compares the incoming score in parallel and the
// chain shifts below the insertion point, so one input item is taken per clock
// while in_stall is low. On the item marked last, the chain turns into an output
// shift register: the head cell drives the result ports and each output transfer
// moves the chain one slot toward the head. The first result shows in the cycle
// after the last item's transfer, and a batch with n kept entries gives n results
// in order, a stalled result holding until it is taken (one result with found low
// if nothing was kept). While these results drain, in_stall is high; the next
// batch starts after the result carrying last_out. The user writes keep_count
// through the cfg port only while idle; the block itself does not enforce it.
// A value of zero acts as one and a value above 16 acts as 16.
module top_k_score_select (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tks_pkg::KEEP_W-1:0]    cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tks_pkg::SCORE_W-1:0]   score,
  input  logic [tks_pkg::GROUP_W-1:0]   group_id,
  input  logic                          is_last,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tks_pkg::GROUP_W-1:0]   group_id_out,
  output logic [tks_pkg::SCORE_W-1:0]   score_out,
  output logic                          found,
  output logic                          last_out
);
  import tks_pkg::*;

  logic [KEEP_W-1:0] keep_count;
  logic [CNT_W-1:0]  keep_eff;
  logic              drain;
  logic              in_xfer;
  logic              out_xfer;
  logic              head_last;

  entry_t            new_entry;
  entry_t            entries [MAX_KEEP];
  logic              gts     [MAX_KEEP];
  cell_ctl_t         ctls    [MAX_KEEP];

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      keep_count <= cfg_data;
    end
  end

  // clamp keep_count into 1..MAX_KEEP
  always_comb begin
    if (keep_count == '0) begin
      keep_eff = CNT_W'(1);
    end else if (keep_count > KEEP_W'(MAX_KEEP)) begin
      keep_eff = CNT_W'(MAX_KEEP);
    end else begin
      keep_eff = CNT_W'(keep_count);
    end
  end

  // handshakes: input held off while the batch results drain
  assign in_stall  = drain;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = drain;
  assign out_xfer  = drain && !out_stall;

  assign new_entry.valid = 1'b1;
  assign new_entry.score = score;
  assign new_entry.group = group_id;

  // the chain
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_g;

    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_e = entries[i-1];
      assign prev_g = gts[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_body
      assign next_e = entries[i+1];
    end

    assign ctls[i].active = (CNT_W'(i) < keep_eff);
    assign ctls[i].insert = in_xfer;
    assign ctls[i].shift  = out_xfer && !head_last;
    assign ctls[i].flush  = out_xfer && head_last;

    tks_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctls[i]),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_gt    (prev_g),
      .next_entry (next_e),
      .entry      (entries[i]),
      .gt         (gts[i])
    );
  end

  // the head result is the last of the batch when nothing valid follows it;
  // slots past the keep count were emptied on the last insert
  if (MAX_KEEP > 1) begin : g_last_multi
    assign head_last = !entries[1].valid;
  end else begin : g_last_single
    assign head_last = 1'b1;
  end

  // drain phase runs from the last item until the final result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      drain <= 1'b0;
    end else if (in_xfer && is_last) begin
      drain <= 1'b1;
    end else if (out_xfer && head_last) begin
      drain <= 1'b0;
    end
  end

  // an empty batch shows zeros with found low
  assign found        = entries[0].valid;
  assign last_out     = head_last;
  assign score_out    = entries[0].valid ? entries[0].score : '0;
  assign group_id_out = entries[0].valid ? entries[0].group : '0;

endmodule

[design/tks_checker.sv]
// tks_checker: port-level assertions for top_k_score_select, bound to the top
// level; uses tks_pkg for field widths
module tks_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        is_last,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [tks_pkg::GROUP_W-1:0] group_id_out,
  input logic [tks_pkg::SCORE_W-1:0] score_out,
  input logic                        found,
  input logic                        last_out
);
  import tks_pkg::*;

  // no input transfer while results are pending
  a_no_input_during_results: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  // the last item of a batch always produces a result
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && is_last) |=> out_valid)
    else $error("no result after last item");

  // the batch ends with the result marked last
  a_batch_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_out) |=> !out_valid)
    else $error("results continue past last_out");

  // an empty-batch result is alone and carries zeros
  a_empty_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (last_out && score_out == '0 && group_id_out == '0))
    else $error("bad empty-batch result");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(score_out)
      && $stable(group_id_out) && $stable(found) && $stable(last_out)))
    else $error("stalled result changed");

endmodule

bind top_k_score_select tks_checker u_tks_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .is_last      (is_last),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .group_id_out (group_id_out),
  .score_out    (score_out),
  .found        (found),
  .last_out     (last_out)
);

[tb/tb.sv]
// tb: self-checking bench for top_k_score_select, a directed stimulus list then random batches
// depends on tks_pkg and top_k_score_select; a built-in rank predictor or a hand-typed expectation checks every result
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tks_pkg::*;

  localparam int LIMIT      = 1_000_000;  // cycles before the run is declared hung
  localparam int N_RANDOM   = 340;        // random input transfers to send
  localparam int N_DIR      = 18;
  localparam int SETTLE     = 20;         // quiet cycles after the last result
  localparam int IDLE_GUARD = 8;          // cycles let pass before a keep_count write

  // one result transfer as seen on the result ports
  typedef struct packed {
    logic [GROUP_W-1:0] group;
    logic [SCORE_W-1:0] score;
    logic               found;
    logic               fin;
  } res_t;

  // one row of the directed list; typed rows carry their single result
  typedef struct packed {
    logic [SCORE_W-1:0] sc;
    logic [GROUP_W-1:0] gid;
    logic               lst;
    logic               typed;
    res_t               want;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [KEEP_W-1:0]  cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [SCORE_W-1:0] score;
  logic [GROUP_W-1:0] group_id;
  logic               is_last;
  logic               out_valid;
  logic               out_stall;
  logic [GROUP_W-1:0] group_id_out;
  logic [SCORE_W-1:0] score_out;
  logic               found;
  logic               last_out;

  // sideband that travels with the input payload: a hand-typed expectation
  logic row_typed;
  res_t row_want;

  // predictor state: its own copy of the register and of the ranked slots
  logic [KEEP_W-1:0] keep_now;
  entry_t            slots [MAX_KEEP];
  res_t              ranked_q [$];   // results still owed by the block

  int errors;
  int cycles;

  top_k_score_select u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .score        (score),
    .group_id     (group_id),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .group_id_out (group_id_out),
    .score_out    (score_out),
    .found        (found),
    .last_out     (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // directed list at the reset keep_count of 8
  dir_row_t dir_rows [N_DIR] = '{
    // empty batch: a zero score never enters, so one result with found low
    '{15'h0000, 16'h1234, 1'b1, 1'b1, '{16'h0000, 15'h0000, 1'b0, 1'b1}},
    // top of both field ranges in a batch of one
    '{15'h7fff, 16'hffff, 1'b1, 1'b1, '{16'hffff, 15'h7fff, 1'b1, 1'b1}},
    // smallest score that can enter, group zero
    '{15'h0001, 16'h0000, 1'b1, 1'b1, '{16'h0000, 15'h0001, 1'b1, 1'b1}},
    // ten rows into eight slots, with ties, a zero and a maximum
    '{15'd5,     16'h0101, 1'b0, 1'b0, '0},
    '{15'd9,     16'h0102, 1'b0, 1'b0, '0},
    '{15'd5,     16'h0103, 1'b0, 1'b0, '0},
    '{15'd0,     16'h0104, 1'b0, 1'b0, '0},
    '{15'h7fff,  16'h0105, 1'b0, 1'b0, '0},
    '{15'd9,     16'h0106, 1'b0, 1'b0, '0},
    '{15'd1,     16'h0107, 1'b0, 1'b0, '0},
    '{15'd5,     16'h0108, 1'b0, 1'b0, '0},
    '{15'd2,     16'h0109, 1'b0, 1'b0, '0},
    '{15'd3,     16'h010a, 1'b1, 1'b0, '0},
    // three equal scores keep their arrival order
    '{15'd7,     16'h0201, 1'b0, 1'b0, '0},
    '{15'd7,     16'h0202, 1'b0, 1'b0, '0},
    '{15'd7,     16'h0203, 1'b1, 1'b0, '0},
    // a lone top bit and the all-ones pattern just below it in both fields
    '{15'h4000,  16'h8000, 1'b0, 1'b0, '0},
    '{15'h3fff,  16'h7fff, 1'b1, 1'b0, '0}
  };

  function automatic int eff_keep(input logic [KEEP_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_KEEP) return MAX_KEEP;
    return int'(v);
  endfunction

  function automatic void clear_slots();
    for (int i = 0; i < MAX_KEEP; i++) slots[i] = '0;
  endfunction

  // insert one row into the ranked slots; on the last row drain them into ranked_q
  function automatic void rank_item(input logic [SCORE_W-1:0] sc,
                                    input logic [GROUP_W-1:0] gid,
                                    input logic lst, input bit emit);
    int k;
    int pos;
    int n;
    res_t r;
    k = eff_keep(keep_now);
    // slots past the current count are dropped before anything else
    for (int i = k; i < MAX_KEEP; i++) slots[i] = '0;
    // first slot holding a lower score; an empty slot reads as zero
    pos = k;
    for (int i = k - 1; i >= 0; i--) begin
      if (sc > (slots[i].valid ? slots[i].score : '0)) pos = i;
    end
    if (pos < k) begin
      for (int j = k - 1; j > pos; j--) slots[j] = slots[j-1];
      slots[pos] = '{valid: 1'b1, score: sc, group: gid};
    end
    if (!lst) return;
    n = 0;
    while (n < k && slots[n].valid) n++;
    if (emit) begin
      if (n == 0) begin
        r = '{group: '0, score: '0, found: 1'b0, fin: 1'b1};
        ranked_q = {ranked_q, r};
      end else begin
        for (int i = 0; i < n; i++) begin
          r = '{group: slots[i].group, score: slots[i].score, found: 1'b1,
                fin: (i == n - 1)};
          ranked_q = {ranked_q, r};
        end
      end
    end
    clear_slots();
  endfunction

  function automatic void flag(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  // everything is sampled here, at the rising edge, before the design's
  // nonblocking updates land; input transfers are predicted before result checks
  always @(posedge clk) begin : scoreboard
    res_t got;
    res_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (rst) begin
      keep_now = KEEP_RESET;
      clear_slots();
    end else begin
      if (cfg_valid && cfg_ready) keep_now = cfg_data;
      if (in_valid && !in_stall) begin
        rank_item(score, group_id, is_last, !row_typed);
        if (row_typed) ranked_q = {ranked_q, row_want};
      end
      if (out_valid && !out_stall) begin
        got = '{group: group_id_out, score: score_out, found: found, fin: last_out};
        if (ranked_q.size() == 0) begin
          flag($sformatf("result with nothing owed: group %h score %h found %b last %b",
                         got.group, got.score, got.found, got.fin));
        end else begin
          want = ranked_q.pop_front();
          if (got.group !== want.group || got.score !== want.score ||
              got.found !== want.found || got.fin !== want.fin) begin
            flag($sformatf("group %h/%h score %h/%h found %b/%b last %b/%b (exp/got)",
                           want.group, got.group, want.score, got.score,
                           want.found, got.found, want.fin, got.fin));
          end
        end
      end
    end
  end

  // gap lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // score mix: zeros, maximum, a narrow band for ties, otherwise full range
  function automatic logic [SCORE_W-1:0] pick_score();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 6) return SCORE_W'($urandom_range(1, 6));
    return SCORE_W'($urandom_range(0, 32767));
  endfunction

  // result side back-pressure: bursts of stall between free stretches,
  // some of those stretches long
  initial begin : result_pressure
    int left;
    out_stall = 1'b0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left > 0) begin
        left--;
      end else if (!out_stall && $urandom_range(0, 2) == 0) begin
        left = pick_gap();
        out_stall <= (left > 0);
      end else begin
        out_stall <= 1'b0;
        left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      end
    end
  end

  // one input transfer; valid stays high across back-to-back items
  task automatic send_item(input logic [SCORE_W-1:0] sc, input logic [GROUP_W-1:0] gid,
                           input logic lst, input logic typed, input res_t want,
                           input bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    score     <= sc;
    group_id  <= gid;
    is_last   <= lst;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // wait until every owed result has arrived, then let the design sit idle;
  // the first check waits for the predictor to see the last input transfer
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    do @(negedge clk); while (ranked_q.size() != 0);
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one batch of rows; an open batch ends without a row marked last
  task automatic run_batch(input int k, input bit close, inout int sent);
    int len;
    int r;
    bit zeros;
    bit calm;
    r = $urandom_range(0, 9);
    zeros = (r == 0);
    if (zeros) len = $urandom_range(1, 3);
    else if (r == 1) len = 1;
    else len = $urandom_range(2, 2 * k + 4);
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      send_item(zeros ? '0 : pick_score(), GROUP_W'($urandom), close && (i == len - 1),
                1'b0, '0, calm);
      sent++;
    end
  endtask

  initial begin : stimulus
    logic [KEEP_W-1:0] corner_keep [6];
    logic [KEEP_W-1:0] kv;
    int sent;
    int phase;
    int batches;
    corner_keep = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2};
    errors    = 0;
    cycles    = 0;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    score     = '0;
    group_id  = '0;
    is_last   = 1'b0;
    row_typed = 1'b0;
    row_want  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed list, run at the reset value of keep_count
    for (int i = 0; i < N_DIR; i++) begin
      send_item(dir_rows[i].sc, dir_rows[i].gid, dir_rows[i].lst,
                dir_rows[i].typed, dir_rows[i].want, 1'b0);
    end

    // random phases: corner keep values first, then random ones; the last
    // batch of a phase is sometimes left open so the new count truncates it
    sent  = 0;
    phase = 0;
    while (sent < N_RANDOM) begin
      wait_drained();
      kv = (phase < 6) ? corner_keep[phase] : KEEP_W'($urandom_range(0, 31));
      write_keep(kv);
      batches = $urandom_range(2, 5);
      for (int b = 0; b < batches; b++) begin
        run_batch(eff_keep(kv), !(b == batches - 1 && $urandom_range(0, 3) == 0), sent);
      end
      phase++;
    end

    // close any open batch so nothing is left in the slots
    send_item(pick_score(), GROUP_W'($urandom), 1'b1, 1'b0, '0, 1'b0);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (ranked_q.size() != 0) flag($sformatf("%0d results never arrived", ranked_q.size()));
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
